>>> hdl/ssir_pkg.sv
package ssir_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 6;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_REMOVED = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } t_command;

endpackage

>>> hdl/ssir_if.sv
interface ssir_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [ssir_pkg::DATA_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface ssir_res_if;
    logic                                valid;
    logic                                ready;
    logic [ssir_pkg::STATUS_W-1:0]       status;
    logic [ssir_pkg::COUNT_W-1:0]        set_count;

    modport source (output valid, output status, output set_count, input ready);
    modport sink   (input valid, input status, input set_count, output ready);
endinterface

>>> hdl/sorted_set_insert_remove_top.sv
// Each command searches the set in order and, for an insert or a removal, shifts the entries
// behind its place; the search stops where the shift starts, so the two together read each
// entry of the store, which has a read and a write port, once, one per cycle, but for the
// larger entry an add stops on, which both read. Commands are taken one at a time; the next
// command is taken once the previous one has finished, even while its result still waits in
// the output register. Reset (synchronous, active low) empties the set; the store is not cleared.
module sorted_set_insert_remove_top #(
    parameter int CAPACITY = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ssir_cmd_if.sink        i_cmd,
    ssir_res_if.source      o_res
);
    import ssir_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_INSERT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    t_command                   r_cmd, n_cmd;
    logic signed [DATA_W-1:0]   r_value, n_value;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_scan, n_scan;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]              r_cmp_idx, n_cmp_idx;
    logic [CW-1:0]              r_pos, n_pos;
    logic [CW-1:0]              r_moves, n_moves;
    logic [IW-1:0]              r_rd_ptr, n_rd_ptr;
    logic                       r_wr_pend, n_wr_pend;
    logic [IW-1:0]              r_wr_addr, n_wr_addr;
    t_status                    r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    t_status                    r_out_status, n_out_status;
    logic [COUNT_W-1:0]         r_out_count, n_out_count;

    logic signed [DATA_W-1:0]   r_mem [CAPACITY];
    logic signed [DATA_W-1:0]   r_rdata;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic signed [DATA_W-1:0]   wr_data;

    logic                       hit;
    logic                       above;
    logic                       scan_end;
    logic [CW-1:0]              stop_pos;
    logic                       out_load;
    logic [CXW-1:0]             count_ext;

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.set_count = r_out_count;

    assign hit       = r_cmp_vld && (r_rdata == r_value);
    assign above     = r_cmp_vld && (r_rdata > r_value);
    assign scan_end  = (r_scan == r_count) && !r_cmp_vld;
    assign stop_pos  = above ? r_cmp_idx : r_count;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    assign count_ext = CXW'(r_count);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_count      = r_count;
        n_scan       = r_scan;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_pos        = r_pos;
        n_moves      = r_moves;
        n_rd_ptr     = r_rd_ptr;
        n_wr_pend    = r_wr_pend;
        n_wr_addr    = r_wr_addr;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        rd_en        = 1'b0;
        rd_addr      = r_scan[IW-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_wr_addr;
        wr_data      = r_rdata;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd     = t_command'(i_cmd.command);
                    n_value   = i_cmd.value;
                    n_scan    = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_cmp_vld = 1'b0;
                    if (r_cmd == CMD_ADD) begin
                        n_status = ST_PRESENT;
                        n_state  = S_DONE;
                    end else begin
                        n_moves   = CW'(r_count - r_cmp_idx - 1'b1);
                        n_rd_ptr  = IW'(r_cmp_idx + 1'b1);
                        n_wr_pend = 1'b0;
                        n_state   = S_SHIFT;
                    end
                end else if (above || scan_end) begin
                    n_cmp_vld = 1'b0;
                    if (r_cmd == CMD_REMOVE) begin
                        n_status = ST_MISSING;
                        n_state  = S_DONE;
                    end else if (r_count == CAP_C) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_pos     = stop_pos;
                        n_moves   = CW'(r_count - stop_pos);
                        n_rd_ptr  = IW'(r_count - 1'b1);
                        n_wr_pend = 1'b0;
                        n_state   = S_SHIFT;
                    end
                end else if (r_scan < r_count) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_scan[IW-1:0];
                    n_scan    = CW'(r_scan + 1'b1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan;
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_wr_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wr_addr;
                    wr_data = r_rdata;
                end
                if (r_moves != '0) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_rd_ptr;
                    n_wr_pend = 1'b1;
                    n_moves   = CW'(r_moves - 1'b1);
                    if (r_cmd == CMD_ADD) begin
                        n_wr_addr = IW'(r_rd_ptr + 1'b1);
                        n_rd_ptr  = IW'(r_rd_ptr - 1'b1);
                    end else begin
                        n_wr_addr = IW'(r_rd_ptr - 1'b1);
                        n_rd_ptr  = IW'(r_rd_ptr + 1'b1);
                    end
                end else begin
                    n_wr_pend = 1'b0;
                    if (!r_wr_pend) begin
                        if (r_cmd == CMD_ADD) begin
                            n_state = S_INSERT;
                        end else begin
                            n_count  = CW'(r_count - 1'b1);
                            n_status = ST_REMOVED;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_INSERT: begin
                wr_en    = 1'b1;
                wr_addr  = r_pos[IW-1:0];
                wr_data  = r_value;
                n_count  = CW'(r_count + 1'b1);
                n_status = ST_ADDED;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = count_ext[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_value      <= n_value;
        r_scan       <= n_scan;
        r_cmp_idx    <= n_cmp_idx;
        r_pos        <= n_pos;
        r_moves      <= n_moves;
        r_rd_ptr     <= n_rd_ptr;
        r_wr_addr    <= n_wr_addr;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("Set size exceeds the capacity.");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ($past(r_state) == S_INSERT || $past(r_state) == S_SHIFT))
        else $error("Set size changed outside an insert or a removal.");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (r_count < CAP_C))
        else $error("Insert started on a full set.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("Finished command did not present its result.");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import ssir_pkg::*;

    localparam int SET_CAP        = 32;
    localparam int RANDOM_ITEMS   = 600;
    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int READY_SPAN     = 128;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } t_ready_mode;

    typedef enum int {
        EP_FILL,
        EP_MIXED,
        EP_DRAIN
    } t_episode;

    typedef struct packed {
        t_command                  cmd;
        logic signed [DATA_W-1:0]  val;
        logic                      fixed;
        t_status                   st;
        logic [COUNT_W-1:0]        cnt;
    } t_set_row;

    typedef struct packed {
        t_status                   st;
        logic [COUNT_W-1:0]        cnt;
    } t_set_result;

    localparam int N_ROWS = 25;

    // Rows with a typed-in result start from an empty set; the rest rely on the set model.
    t_set_row set_rows [N_ROWS] = '{
        '{CMD_REMOVE, 32'sh0000_0000, 1'b1, ST_MISSING, 6'd0},
        '{CMD_ADD,    32'sh8000_0000, 1'b1, ST_ADDED,   6'd1},
        '{CMD_ADD,    32'sh7FFF_FFFF, 1'b1, ST_ADDED,   6'd2},
        '{CMD_ADD,    32'sh7FFF_FFFF, 1'b1, ST_PRESENT, 6'd2},
        '{CMD_ADD,    32'sh0000_0000, 1'b1, ST_ADDED,   6'd3},
        '{CMD_ADD,    32'shFFFF_FFFF, 1'b1, ST_ADDED,   6'd4},
        '{CMD_ADD,    32'sh0000_0001, 1'b1, ST_ADDED,   6'd5},
        '{CMD_ADD,    32'sh8000_0001, 1'b1, ST_ADDED,   6'd6},
        '{CMD_ADD,    32'sh7FFF_FFFE, 1'b1, ST_ADDED,   6'd7},
        '{CMD_ADD,    32'sh8000_0000, 1'b1, ST_PRESENT, 6'd7},
        '{CMD_REMOVE, 32'sh0000_0002, 1'b1, ST_MISSING, 6'd7},
        '{CMD_REMOVE, 32'sh0000_0000, 1'b1, ST_REMOVED, 6'd6},
        '{CMD_REMOVE, 32'sh0000_0000, 1'b1, ST_MISSING, 6'd6},
        '{CMD_REMOVE, 32'sh8000_0000, 1'b1, ST_REMOVED, 6'd5},
        '{CMD_REMOVE, 32'sh7FFF_FFFF, 1'b1, ST_REMOVED, 6'd4},
        '{CMD_ADD,    32'sh5555_5555, 1'b0, ST_ADDED,   6'd0},
        '{CMD_ADD,    32'shAAAA_AAAA, 1'b0, ST_ADDED,   6'd0},
        '{CMD_REMOVE, 32'shFFFF_FFFF, 1'b0, ST_ADDED,   6'd0},
        '{CMD_ADD,    32'sh0000_0000, 1'b0, ST_ADDED,   6'd0},
        '{CMD_REMOVE, 32'sh5555_5555, 1'b0, ST_ADDED,   6'd0},
        '{CMD_REMOVE, 32'sh0000_0001, 1'b0, ST_ADDED,   6'd0},
        '{CMD_REMOVE, 32'sh8000_0001, 1'b0, ST_ADDED,   6'd0},
        '{CMD_REMOVE, 32'sh7FFF_FFFE, 1'b0, ST_ADDED,   6'd0},
        '{CMD_REMOVE, 32'shAAAA_AAAA, 1'b0, ST_ADDED,   6'd0},
        '{CMD_REMOVE, 32'sh0000_0000, 1'b0, ST_ADDED,   6'd0}
    };

    logic i_clk;
    logic i_rst_n;

    ssir_cmd_if cmd_bus ();
    ssir_res_if res_bus ();

    sorted_set_insert_remove_top #(
        .CAPACITY (SET_CAP)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    logic signed [DATA_W-1:0] model_set [$];
    t_set_result              pending_results [$];
    t_set_result              oldest_result;
    int                       error_count = 0;
    int                       idle_cycles = 0;
    int                       burst_left  = 0;
    int                       items_sent  = 0;
    int                       ready_tick  = 0;
    int                       ready_phase = 0;
    t_ready_mode              ready_mode  = RDY_ALWAYS;
    t_episode                 episode;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR at %0t: %s, got %0d, wanted %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic t_status model_command(input t_command cmd,
                                              input logic signed [DATA_W-1:0] val);
        int pos;
        bit hit;
        pos = 0;
        hit = 1'b0;
        foreach (model_set[j]) begin
            if (model_set[j] == val)
                hit = 1'b1;
            else if (model_set[j] < val)
                pos++;
        end
        if (cmd == CMD_ADD) begin
            if (hit)
                return ST_PRESENT;
            if (model_set.size() >= SET_CAP)
                return ST_FULL;
            model_set.insert(pos, val);
            return ST_ADDED;
        end
        if (!hit)
            return ST_MISSING;
        model_set.delete(pos);
        return ST_REMOVED;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return $signed($urandom_range(0, 47)) - 32'sd24;
        if (roll < 48)
            return 32'sh8000_0000 + $signed($urandom_range(0, 3));
        if (roll < 55)
            return 32'sh7FFF_FFFF - $signed($urandom_range(0, 3));
        return $signed($urandom());
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_member();
        if (model_set.size() == 0)
            return pick_value();
        return model_set[$urandom_range(0, model_set.size() - 1)];
    endfunction

    task automatic issue_command(input t_command cmd, input logic signed [DATA_W-1:0] val,
                                 input bit fixed = 1'b0, input t_status fix_st = ST_ADDED,
                                 input logic [COUNT_W-1:0] fix_cnt = '0);
        int gap;
        t_set_result res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= cmd;
        cmd_bus.value   <= val;
        do @(posedge i_clk); while (!cmd_bus.ready);
        res.st  = model_command(cmd, val);
        res.cnt = COUNT_W'(model_set.size());
        if (fixed) begin
            res.st  = fix_st;
            res.cnt = fix_cnt;
        end
        pending_results.push_back(res);
        items_sent++;
    endtask

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing pending", res_bus.status, -1);
            end else begin
                oldest_result = pending_results.pop_front();
                if (res_bus.status !== oldest_result.st)
                    report_mismatch("status", res_bus.status, oldest_result.st);
                if (res_bus.set_count !== oldest_result.cnt)
                    report_mismatch("set_count", res_bus.set_count, oldest_result.cnt);
            end
        end
    end

    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_tick == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                ready_tick = READY_SPAN;
            end
            ready_tick--;
            ready_phase++;
            case (ready_mode)
                RDY_ALWAYS:   res_bus.ready <= 1'b1;
                RDY_COIN:     res_bus.ready <= 1'($urandom_range(0, 1));
                RDY_PERIODIC: res_bus.ready <= ((ready_phase % 8) >= 3);
                default:      res_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("ERROR at %0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("sorted_set_insert_remove_top: mismatch");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.command <= CMD_ADD;
        cmd_bus.value   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (set_rows[r])
            issue_command(set_rows[r].cmd, set_rows[r].val, set_rows[r].fixed,
                          set_rows[r].st, set_rows[r].cnt);

        while (items_sent < N_ROWS + RANDOM_ITEMS) begin
            episode = t_episode'($urandom_range(0, 2));
            case (episode)
                EP_FILL: begin
                    while (model_set.size() < SET_CAP) begin
                        if ($urandom_range(0, 9) == 0)
                            issue_command(CMD_REMOVE, pick_member());
                        else
                            issue_command(CMD_ADD, ($urandom_range(0, 3) == 0) ?
                                          pick_value() : $signed($urandom()));
                    end
                    repeat ($urandom_range(2, 6))
                        issue_command(CMD_ADD, $urandom_range(0, 1) ?
                                      pick_member() : $signed($urandom()));
                    repeat ($urandom_range(4, SET_CAP))
                        issue_command(CMD_REMOVE, ($urandom_range(0, 6) == 0) ?
                                      pick_value() : pick_member());
                end
                EP_MIXED: begin
                    repeat (24) begin
                        if ($urandom_range(0, 99) < 55)
                            issue_command(CMD_ADD, pick_value());
                        else
                            issue_command(CMD_REMOVE, $urandom_range(0, 1) ?
                                          pick_member() : pick_value());
                    end
                end
                default: begin
                    while (model_set.size() > 0) begin
                        if ($urandom_range(0, 9) == 0)
                            issue_command(CMD_ADD, pick_value());
                        else
                            issue_command(CMD_REMOVE, ($urandom_range(0, 4) == 0) ?
                                          pick_value() : pick_member());
                    end
                    issue_command(CMD_REMOVE, pick_value());
                end
            endcase
        end
        cmd_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("sorted_set_insert_remove_top: match");
        else
            $display("sorted_set_insert_remove_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hdl/ssir_pkg.sv
hdl/ssir_if.sv
hdl/sorted_set_insert_remove_top.sv
tb/testbench.sv
